// File: rtl/tgad_pkg.sv
// Shared types and constants for the TGA stream decoder.
`timescale 1ns / 1ps

package tgad_pkg;

   // result kinds carried on rsp_tuser
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // header byte positions
   localparam logic [4:0] HDR_TYPE      = 5'd2;
   localparam logic [4:0] HDR_SIG_LAST  = 5'd11;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_DEPTH     = 5'd16;
   localparam logic [4:0] HDR_DESC      = 5'd17;

   // image type codes and depths
   localparam logic [7:0] TYPE_RAW  = 8'd2;
   localparam logic [7:0] TYPE_RLE  = 8'd10;
   localparam logic [7:0] DEPTH_24  = 8'd24;
   localparam logic [7:0] DEPTH_32  = 8'd32;
   localparam logic [7:0] RUN_FLAG  = 8'd128;
   localparam logic [7:0] RUN_BIAS  = 8'd127;
   localparam logic [7:0] ALPHA_MAX = 8'd255;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_PIXELS = 3'b010,
      PH_IDLE   = 3'b100
   } phase_type;

   // header parser status toward the top and pixel unit
   typedef struct packed {
      logic        done;        // header finished on this byte
      logic        reject;
      logic        empty;       // width or height is zero
      logic        four_byte;   // 32-bit pixels
      logic        compressed;  // run-length coded
      logic [15:0] width;       // stored values
      logic [15:0] height;
      logic [15:0] out_width;   // values reported on the header result
      logic [15:0] out_height;
   } hdr_info_type;

   // pixel unit status
   typedef struct packed {
      logic        valid;       // a pixel result on this byte
      logic        last;
      logic        drained;     // no pixels were left
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  count;
   } pix_info_type;

endpackage

// File: rtl/tgad_header.sv
// Header parser: signature check, dimensions and depth.
`timescale 1ns / 1ps

module tgad_header import tgad_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         sof,
   input  logic [7:0]   data_byte,
   output hdr_info_type info
);

   logic [4:0]  index_ff, index_in;
   logic        mismatch_ff, mismatch_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        four_ff, four_in;
   logic        comp_ff, comp_in;

   logic [4:0]  idx;
   logic        mis;

   always_comb begin
      // start of file restarts the parse on this byte
      idx        = sof ? 5'd0 : index_ff;
      mis        = sof ? 1'b0 : mismatch_ff;
      index_in   = idx;
      mismatch_in = mis;
      width_in   = sof ? 16'd0 : width_ff;
      height_in  = sof ? 16'd0 : height_ff;
      four_in    = sof ? 1'b0 : four_ff;
      comp_in    = sof ? 1'b0 : comp_ff;
      info       = '0;
      info.width      = width_ff;
      info.height     = height_ff;
      info.four_byte  = four_ff;
      info.compressed = comp_ff;

      if (idx <= HDR_SIG_LAST) begin
         if (idx == HDR_TYPE) begin
            if (data_byte == TYPE_RLE) begin
               comp_in = 1'b1;
            end else if (data_byte != TYPE_RAW) begin
               mismatch_in = 1'b1;
            end
         end else if (data_byte != 8'd0) begin
            mismatch_in = 1'b1;
         end
         index_in = idx + 5'd1;
         if (idx == HDR_SIG_LAST && mismatch_in) begin
            info.done   = 1'b1;
            info.reject = 1'b1;
         end
      end else begin
         case (idx)
            HDR_WIDTH_LO:  width_in  = {width_ff[15:8], data_byte};
            HDR_WIDTH_HI:  width_in  = {data_byte, width_ff[7:0]};
            HDR_HEIGHT_LO: height_in = {height_ff[15:8], data_byte};
            HDR_HEIGHT_HI: height_in = {data_byte, height_ff[7:0]};
            HDR_DEPTH: begin
               four_in = (data_byte == DEPTH_32);
               if (data_byte != DEPTH_24 && data_byte != DEPTH_32) begin
                  mismatch_in = 1'b1;
               end
            end
            default: ;
         endcase
         if (idx < HDR_DESC) begin
            index_in = idx + 5'd1;
         end else begin
            info.done       = 1'b1;
            info.reject     = mis;
            info.empty      = (width_ff == 16'd0) || (height_ff == 16'd0);
            info.out_width  = width_ff;
            info.out_height = height_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= '0;
         mismatch_ff <= 1'b0;
         width_ff    <= '0;
         height_ff   <= '0;
         four_ff     <= 1'b0;
         comp_ff     <= 1'b0;
      end else if (step) begin
         index_ff    <= index_in;
         mismatch_ff <= mismatch_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         four_ff     <= four_in;
         comp_ff     <= comp_in;
      end
   end

endmodule

// File: rtl/tgad_pixel.sv
// Pixel unit: packet headers, pixel assembly, run counting.
`timescale 1ns / 1ps

module tgad_pixel import tgad_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic         load,
   input  logic         four_byte,
   input  logic         compressed,
   input  logic [15:0]  width,
   input  logic [15:0]  height,
   input  logic [7:0]   data_byte,
   output pix_info_type info
);

   logic [7:0]  packet_ff, packet_in;
   logic        run_ff, run_in;
   logic [1:0]  byte_idx_ff, byte_idx_in;
   logic [23:0] bytes_ff, bytes_in;
   logic [31:0] left_ff, left_in;

   logic [1:0]  last_idx;
   logic        emit;
   logic [7:0]  alpha;
   logic [7:0]  count;
   logic [7:0]  count_c;

   always_comb begin
      packet_in   = packet_ff;
      run_in      = run_ff;
      byte_idx_in = byte_idx_ff;
      bytes_in    = bytes_ff;
      left_in     = left_ff;
      last_idx    = four_byte ? 2'd3 : 2'd2;
      emit        = 1'b0;
      alpha       = ALPHA_MAX;
      count       = 8'd1;
      count_c     = 8'd1;
      info        = '0;

      if (load) begin
         packet_in   = '0;
         run_in      = 1'b0;
         byte_idx_in = '0;
         bytes_in    = '0;
         left_in     = {16'd0, width} * {16'd0, height};
      end else if (step) begin
         if (left_ff == 32'd0) begin
            info.drained = 1'b1;
         end else if (compressed && packet_ff == 8'd0) begin
            // packet header byte
            if (data_byte < RUN_FLAG) begin
               packet_in = data_byte + 8'd1;
               run_in    = 1'b0;
            end else begin
               packet_in = data_byte - RUN_BIAS;
               run_in    = 1'b1;
            end
         end else begin
            // stored order is B, G, R, A
            case (byte_idx_ff)
               2'd0:    bytes_in[7:0]   = data_byte;
               2'd1:    bytes_in[15:8]  = data_byte;
               2'd2:    bytes_in[23:16] = data_byte;
               default: alpha           = data_byte;
            endcase
            if (byte_idx_ff != last_idx) begin
               byte_idx_in = byte_idx_ff + 2'd1;
            end else begin
               emit = 1'b1;
            end
         end

         if (emit) begin
            byte_idx_in = '0;
            if (compressed && run_ff) begin
               count     = packet_ff;
               packet_in = '0;
            end else begin
               count = 8'd1;
               if (compressed) begin
                  packet_in = packet_ff - 8'd1;
               end
            end
            // clamp the run to what is left of the image
            count_c    = ({24'd0, count} > left_ff) ? left_ff[7:0] : count;
            left_in    = left_ff - {24'd0, count_c};
            info.valid = 1'b1;
            info.last  = (left_in == 32'd0);
            info.red   = bytes_in[23:16];
            info.green = bytes_in[15:8];
            info.blue  = bytes_in[7:0];
            info.alpha = alpha;
            info.count = count_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_ff   <= '0;
         run_ff      <= 1'b0;
         byte_idx_ff <= '0;
         bytes_ff    <= '0;
         left_ff     <= '0;
      end else begin
         packet_ff   <= packet_in;
         run_ff      <= run_in;
         byte_idx_ff <= byte_idx_in;
         bytes_ff    <= bytes_in;
         left_ff     <= left_in;
      end
   end

endmodule

// File: rtl/tga_image_stream_decoder.sv
// Top level of the TGA stream decoder: input register, control, result register.
`timescale 1ns / 1ps

// Decodes a TGA file presented one byte per transaction on the req_ channel.
// Assert req_tuser with the first byte of each file; it restarts the header
// parse at any time. The 12-byte signature must be type 2 (raw) or 10
// (run-length) with all other bytes zero, else a reject result follows the
// 12th byte. Bytes 12..17 give width, height, depth (24 or 32) and an
// ignored descriptor; the 18th byte yields an accept or a reject (bad depth)
// result carrying width and height. Pixels follow as kind 0 results in RGBA
// order, alpha 255 for 24-bit data; a run packet gives a single result whose
// run_length holds its repeat count, clamped to the pixels remaining.
// rsp_tlast marks the result that completes the image (also an accept of an
// empty image); after that, or after a reject, bytes are dropped until the
// next start of file. Throughput is one byte per clock while the result
// register can take a result: every byte passes the input register, the
// combinational decode and the result register, which drives rsp_tvalid.
// A byte is held only while the result register is full and rsp_tready
// is low. No initialization pass is needed after reset.
module tga_image_stream_decoder import tgad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request: one file byte per transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_file
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                    // [31:24] alpha, [39:32] run_length,
                                    // [55:40] image_width, [71:56] image_height
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_image
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  data_ff;
   logic        sof_ff;

   // parse phase
   phase_type   phase_ff, phase_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  alpha_ff, alpha_in;
   logic [7:0]  run_ff, run_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        last_ff, last_in;

   logic         space;
   logic         step;
   logic         hdr_step;
   logic         pix_step;
   logic         pix_load;
   logic         has_result;
   hdr_info_type hdr;
   pix_info_type pix;

   assign space      = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && space;
   assign req_tready = !in_valid_ff || step;

   assign hdr_step = step && (sof_ff || phase_ff == PH_HEADER);
   assign pix_step = step && !sof_ff && phase_ff == PH_PIXELS;
   assign pix_load = hdr_step && hdr.done && !hdr.reject;

   tgad_header u_header (
      .clock     (clock),
      .reset     (reset),
      .step      (hdr_step),
      .sof       (sof_ff),
      .data_byte (data_ff),
      .info      (hdr)
   );

   tgad_pixel u_pixel (
      .clock      (clock),
      .reset      (reset),
      .step       (pix_step),
      .load       (pix_load),
      .four_byte  (hdr.four_byte),
      .compressed (hdr.compressed),
      .width      (hdr.width),
      .height     (hdr.height),
      .data_byte  (data_ff),
      .info       (pix)
   );

   assign has_result = (hdr_step && hdr.done) || (pix_step && pix.valid);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      phase_in = phase_ff;
      if (step) begin
         phase_in = sof_ff ? PH_HEADER : phase_ff;
         if (hdr_step && hdr.done) begin
            if (hdr.reject || hdr.empty) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_PIXELS;
            end
         end else if (pix_step && (pix.drained || (pix.valid && pix.last))) begin
            phase_in = PH_IDLE;
         end
      end

      out_valid_in = out_valid_ff;
      if (step && has_result) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      kind_in   = KIND_PIXEL;
      red_in    = '0;
      green_in  = '0;
      blue_in   = '0;
      alpha_in  = '0;
      run_in    = '0;
      width_in  = '0;
      height_in = '0;
      last_in   = 1'b0;
      if (hdr_step && hdr.done) begin
         kind_in   = hdr.reject ? KIND_REJECT : KIND_ACCEPT;
         width_in  = hdr.out_width;
         height_in = hdr.out_height;
         last_in   = !hdr.reject && hdr.empty;
      end else begin
         red_in   = pix.red;
         green_in = pix.green;
         blue_in  = pix.blue;
         alpha_in = pix.alpha;
         run_in   = pix.count;
         last_in  = pix.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_HEADER;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= req_tdata;
         sof_ff  <= req_tuser;
      end
      if (step && has_result) begin
         kind_ff   <= kind_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         alpha_ff  <= alpha_in;
         run_ff    <= run_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {height_ff, width_ff, run_ff, alpha_ff, blue_ff, green_ff, red_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   // header and pixel units never both report on one byte
   assert property (@(posedge clock) disable iff (reset)
      !(hdr_step && hdr.done && pix_step && pix.valid))
      else $error("header and pixel results collide");

   // a byte is only decoded when the result register can take its result
   assert property (@(posedge clock) disable iff (reset)
      step |-> (!out_valid_ff || rsp_tready))
      else $error("result register overrun");

   // the pixel that completes the image leaves the parser idle
   assert property (@(posedge clock) disable iff (reset)
      (pix_step && pix.valid && pix.last) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after last pixel");

   // a pixel result always covers at least one pixel
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && kind_ff == KIND_PIXEL) |-> (run_ff != 8'd0))
      else $error("empty pixel run reported");

endmodule

// File: sim/tga_image_stream_decoder_tb.sv
// Self-checking testbench for the TGA stream decoder: byte-level decode model and result checks.
`timescale 1ns / 1ps

module tga_image_stream_decoder_tb import tgad_pkg::*;;

   localparam int CYCLE_LIMIT  = 150000;  // far above the slowest legal run
   localparam int RANDOM_BYTES = 100;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 300;

   // one decoded result, fields as carried on rsp_tdata / rsp_tuser / rsp_tlast
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  run_length;
      logic [15:0] width;
      logic [15:0] height;
      logic        last;
   } tga_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] data_byte
   logic        req_tuser = 1'b0;   // [0] start_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;          // [7:0] red ... [71:56] image_height
   logic [1:0]  rsp_tuser;          // [1:0] kind
   logic        rsp_tlast;

   tga_image_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   // run bookkeeping
   tga_result_type expected_results[$];
   int          bytes_taken = 0;
   int          results_checked = 0;
   int          files_sent = 0;
   int          errors = 0;
   int          cycle_count = 0;
   bit          req_gaps = 1'b1;
   bit          rsp_gaps = 1'b1;
   int          rsp_hold_cycles = 0;

   // decoder state as seen from the byte stream
   phase_type   dec_phase;
   logic [4:0]  hdr_pos;
   logic        hdr_bad;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic        px_four;
   logic        rle_mode;
   logic [7:0]  pkt_left;
   logic        pkt_is_run;
   logic [1:0]  px_pos;
   logic [23:0] px_color;
   logic [31:0] px_remaining;

   function automatic void clear_decoder();
      dec_phase    = PH_HEADER;
      hdr_pos      = '0;
      hdr_bad      = 1'b0;
      img_w        = '0;
      img_h        = '0;
      px_four      = 1'b0;
      rle_mode     = 1'b0;
      pkt_left     = '0;
      pkt_is_run   = 1'b0;
      px_pos       = '0;
      px_color     = '0;
      px_remaining = '0;
   endfunction

   // Advances the decode state by one byte; returns 1 when the byte yields a result.
   function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                      output tga_result_type r);
      int          need;
      logic [7:0]  alpha;
      logic [31:0] count;
      r = '0;
      if (sof) clear_decoder();
      case (dec_phase)
         PH_HEADER: begin
            if (hdr_pos <= HDR_SIG_LAST) begin
               if (hdr_pos == HDR_TYPE) begin
                  if (b == TYPE_RLE) rle_mode = 1'b1;
                  else if (b != TYPE_RAW) hdr_bad = 1'b1;
               end else if (b != 8'd0) begin
                  hdr_bad = 1'b1;
               end
               if (hdr_pos == HDR_SIG_LAST && hdr_bad) begin
                  // signature reject carries no dimensions
                  hdr_pos++;
                  r.kind = KIND_REJECT;
                  dec_phase = PH_IDLE;
                  return 1'b1;
               end
               hdr_pos++;
               return 1'b0;
            end
            case (hdr_pos)
               HDR_WIDTH_LO:  img_w[7:0]  = b;
               HDR_WIDTH_HI:  img_w[15:8] = b;
               HDR_HEIGHT_LO: img_h[7:0]  = b;
               HDR_HEIGHT_HI: img_h[15:8] = b;
               HDR_DEPTH: begin
                  px_four = (b == DEPTH_32);
                  if (b != DEPTH_24 && b != DEPTH_32) hdr_bad = 1'b1;
               end
               default: ;
            endcase
            if (hdr_pos < HDR_DESC) begin
               hdr_pos++;
               return 1'b0;
            end
            r.width  = img_w;
            r.height = img_h;
            if (hdr_bad) begin
               r.kind = KIND_REJECT;
               dec_phase = PH_IDLE;
               return 1'b1;
            end
            r.kind       = KIND_ACCEPT;
            px_remaining = 32'(img_w) * 32'(img_h);
            pkt_left     = '0;
            pkt_is_run   = 1'b0;
            px_pos       = '0;
            px_color     = '0;
            if (px_remaining == 0) begin
               r.last = 1'b1;
               dec_phase = PH_IDLE;
            end else begin
               dec_phase = PH_PIXELS;
            end
            return 1'b1;
         end
         PH_PIXELS: begin
            if (px_remaining == 0) begin
               dec_phase = PH_IDLE;
               return 1'b0;
            end
            if (rle_mode && pkt_left == 0) begin
               // packet header: low seven bits plus one give the count
               if (b < RUN_FLAG) begin
                  pkt_left   = b + 8'd1;
                  pkt_is_run = 1'b0;
               end else begin
                  pkt_left   = b - RUN_BIAS;
                  pkt_is_run = 1'b1;
               end
               return 1'b0;
            end
            need = px_four ? 4 : 3;
            if (px_pos < 2'd3) begin
               px_color[8*px_pos +: 8] = b;
               if (int'(px_pos) + 1 < need) begin
                  px_pos++;
                  return 1'b0;
               end
               alpha = ALPHA_MAX;
            end else begin
               alpha = b;
            end
            px_pos = '0;
            if (rle_mode && pkt_is_run) begin
               count    = 32'(pkt_left);
               pkt_left = '0;
            end else begin
               count = 32'd1;
               if (rle_mode) pkt_left--;
            end
            // a run never reaches past the end of the image
            if (count > px_remaining) count = px_remaining;
            px_remaining -= count;
            r.kind       = KIND_PIXEL;
            r.red        = px_color[23:16];
            r.green      = px_color[15:8];
            r.blue       = px_color[7:0];
            r.alpha      = alpha;
            r.run_length = count[7:0];
            if (px_remaining == 0) begin
               r.last = 1'b1;
               dec_phase = PH_IDLE;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // input side: every accepted byte goes through the decode model
   always @(posedge clock) begin : byte_monitor
      tga_result_type r;
      if (!reset && req_tvalid && req_tready) begin
         bytes_taken++;
         if (decode_byte(req_tdata, req_tuser, r)) expected_results.push_back(r);
      end
   end

   // output side: each accepted result against the oldest prediction
   always @(posedge clock) begin : result_check
      tga_result_type got;
      tga_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = rsp_tuser;
         got.red        = rsp_tdata[7:0];
         got.green      = rsp_tdata[15:8];
         got.blue       = rsp_tdata[23:16];
         got.alpha      = rsp_tdata[31:24];
         got.run_length = rsp_tdata[39:32];
         got.width      = rsp_tdata[55:40];
         got.height     = rsp_tdata[71:56];
         got.last       = rsp_tlast;
         results_checked++;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual kind %0d data %h last %b",
                     $time, got.kind, rsp_tdata, got.last);
         end else begin
            want = expected_results.pop_front();
            check_field("kind",          16'(want.kind),       16'(got.kind));
            check_field("red",           16'(want.red),        16'(got.red));
            check_field("green",         16'(want.green),      16'(got.green));
            check_field("blue",          16'(want.blue),       16'(got.blue));
            check_field("alpha",         16'(want.alpha),      16'(got.alpha));
            check_field("run_length",    16'(want.run_length), 16'(got.run_length));
            check_field("image_width",   want.width,           got.width);
            check_field("image_height",  want.height,          got.height);
            check_field("last_of_image", 16'(want.last),       16'(got.last));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(rsp_gaps && $urandom_range(0, 99) < 35);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_results.size());
         $display("** tga_image_stream_decoder: FAILED **");
         $finish;
      end
   end

   // Offers one byte and returns at the falling edge after its transaction.
   task automatic send_byte(input logic [7:0] b, input logic sof);
      while (req_gaps && $urandom_range(0, 99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sof;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // 18-byte header; flaw_pos >= 0 puts flaw_val into that signature byte
   task automatic send_header(input logic [7:0] type_code, input logic [15:0] w,
                              input logic [15:0] h, input logic [7:0] depth,
                              input int flaw_pos, input logic [7:0] flaw_val);
      logic [7:0] v;
      files_sent++;
      for (int pos = 0; pos <= int'(HDR_SIG_LAST); pos++) begin
         v = (pos == int'(HDR_TYPE)) ? type_code : 8'd0;
         if (pos == flaw_pos) v = flaw_val;
         send_byte(v, pos == 0);
      end
      send_byte(w[7:0], 1'b0);
      send_byte(w[15:8], 1'b0);
      send_byte(h[7:0], 1'b0);
      send_byte(h[15:8], 1'b0);
      send_byte(depth, 1'b0);
      send_byte(8'($urandom), 1'b0);   // descriptor, ignored
   endtask

   // file order is B, G, R, then A for 32-bit data
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [7:0] a, input bit four);
      send_byte(b, 1'b0);
      send_byte(g, 1'b0);
      send_byte(r, 1'b0);
      if (four) send_byte(a, 1'b0);
   endtask

   task automatic send_random_pixel(input bit four);
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), four);
   endtask

   // Pixel data for an image of the given size; some packets overrun the end,
   // and with stop_early the file may be cut short.
   task automatic send_image_body(input int unsigned pixels, input bit four, input bit rle,
                                  input bit stop_early);
      int unsigned left;
      int unsigned n;
      left = pixels;
      while (left > 0) begin
         if (stop_early && $urandom_range(0, 9) == 0) return;
         if (!rle) begin
            send_random_pixel(four);
            left--;
         end else begin
            n = $urandom_range(1, (left < 128) ? left : 128);
            if ($urandom_range(0, 9) == 0) n = (left + 4 < 128) ? left + 4 : 128;
            if ($urandom_range(0, 1)) begin
               send_byte(8'(RUN_BIAS + n), 1'b0);
               send_random_pixel(four);
               left = (n < left) ? left - n : 0;
            end else begin
               send_byte(8'(n - 1), 1'b0);
               // all bytes of the packet are sent; those past the image end are dropped
               repeat (n) begin
                  send_random_pixel(four);
                  if (left > 0) left--;
               end
            end
         end
      end
   endtask

   task automatic test_raw_pixels();
      send_header(TYPE_RAW, 16'd2, 16'd1, DEPTH_24, -1, 8'd0);
      send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_header(TYPE_RAW, 16'd1, 16'd2, DEPTH_32, -1, 8'd0);
      send_pixel(8'h01, 8'h80, 8'h7F, 8'h00, 1'b1);
      send_pixel(8'hFE, 8'h7F, 8'h80, 8'hFF, 1'b1);
   endtask

   task automatic test_run_length();
      // run of two, then a raw packet of one
      send_header(TYPE_RLE, 16'd3, 16'd1, DEPTH_24, -1, 8'd0);
      send_byte(8'h81, 1'b0);
      send_pixel(8'h12, 8'h34, 8'h56, 8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_pixel(8'hA5, 8'h5A, 8'hC3, 8'h00, 1'b0);
      // longest run clamped to the four pixels left, trailing bytes dropped
      send_header(TYPE_RLE, 16'd2, 16'd2, DEPTH_32, -1, 8'd0);
      send_byte(8'hFF, 1'b0);
      send_pixel(8'h11, 8'h22, 8'h33, 8'h44, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hFF, 1'b0);
      // raw packet of three in a two-pixel image ends inside the packet
      send_header(TYPE_RLE, 16'd2, 16'd1, DEPTH_24, -1, 8'd0);
      send_byte(8'h02, 1'b0);
      send_pixel(8'h01, 8'h02, 8'h03, 8'h00, 1'b0);
      send_pixel(8'h04, 8'h05, 8'h06, 8'h00, 1'b0);
      send_pixel(8'h07, 8'h08, 8'h09, 8'h00, 1'b0);
   endtask

   task automatic test_header_rejects();
      send_header(TYPE_RAW, 16'd1, 16'd1, DEPTH_24, 0, 8'h80);    // bad signature byte
      send_header(8'd3, 16'd1, 16'd1, DEPTH_24, -1, 8'd0);        // unknown image type
      send_header(TYPE_RLE, 16'h1234, 16'hABCD, 8'd16, -1, 8'd0); // unsupported depth
      send_pixel(8'h55, 8'hAA, 8'h55, 8'h00, 1'b0);               // ignored until next file
      send_header(TYPE_RAW, 16'hFFFF, 16'h0001, 8'hFF, -1, 8'd0);
   endtask

   task automatic test_empty_image();
      send_header(TYPE_RAW, 16'd0, 16'hFFFF, DEPTH_24, -1, 8'd0);
      send_pixel(8'h01, 8'h02, 8'h03, 8'h00, 1'b0);
      send_header(TYPE_RLE, 16'hFFFF, 16'd0, DEPTH_32, -1, 8'd0);
   endtask

   task automatic test_restart();
      // restart inside a header, then inside pixel data
      files_sent++;
      send_byte(8'd0, 1'b1);
      repeat (6) send_byte(8'd0, 1'b0);
      send_header(TYPE_RAW, 16'd2, 16'd2, DEPTH_24, -1, 8'd0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h20, 1'b0);
      send_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_24, -1, 8'd0);
      send_byte(8'h80, 1'b0);
      send_pixel(8'h9A, 8'hBC, 8'hDE, 8'h00, 1'b0);
   endtask

   task automatic test_truncated();
      // a huge image left unfinished; the next file's start of file recovers
      send_header(TYPE_RAW, 16'hFFFF, 16'hFFFF, DEPTH_32, -1, 8'd0);
      repeat (5) send_random_pixel(1'b1);
      send_byte(8'h33, 1'b0);
   endtask

   task automatic test_output_stall();
      // no idling on either side; the receiver holds off while bytes keep coming
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      send_header(TYPE_RAW, 16'd4, 16'd4, DEPTH_24, -1, 8'd0);
      send_image_body(16, 1'b0, 1'b0, 1'b0);
      send_header(TYPE_RLE, 16'd5, 16'd3, DEPTH_32, -1, 8'd0);
      send_image_body(15, 1'b1, 1'b1, 1'b0);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   task automatic test_random_files();
      int          first;
      int unsigned pick;
      int unsigned w;
      int unsigned h;
      bit          four;
      bit          rle;
      int          pos;
      logic [7:0]  v;
      first = bytes_taken;
      while (bytes_taken - first < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         four = $urandom_range(0, 1);
         rle  = $urandom_range(0, 1);
         if (pick < 75) begin
            // well-formed file, mostly tiny, a few wider, some cut short
            w = $urandom_range(1, 4);
            h = $urandom_range(1, 4);
            if ($urandom_range(0, 19) == 0) w = $urandom_range(8, 16);
            send_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h),
                        four ? DEPTH_32 : DEPTH_24, -1, 8'd0);
            send_image_body(w * h, four, rle, $urandom_range(0, 19) == 0);
         end else if (pick < 85) begin
            // broken header: signature byte, image type or depth
            case ($urandom_range(0, 2))
               0: begin
                  do pos = $urandom_range(0, int'(HDR_SIG_LAST));
                  while (pos == int'(HDR_TYPE));
                  send_header(TYPE_RAW, 16'($urandom), 16'($urandom), DEPTH_24,
                              pos, 8'($urandom_range(1, 255)));
               end
               1: begin
                  do v = 8'($urandom); while (v == TYPE_RAW || v == TYPE_RLE);
                  send_header(v, 16'($urandom), 16'($urandom), DEPTH_32, -1, 8'd0);
               end
               default: begin
                  do v = 8'($urandom); while (v == DEPTH_24 || v == DEPTH_32);
                  send_header(TYPE_RLE, 16'($urandom), 16'($urandom), v, -1, 8'd0);
               end
            endcase
            repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0);
         end else if (pick < 92) begin
            // large dimensions: empty images, or big images cut short
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
            if ($urandom_range(0, 1)) begin
               if ($urandom_range(0, 1)) w = 0; else h = 0;
            end
            send_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h),
                        four ? DEPTH_32 : DEPTH_24, -1, 8'd0);
            if (w * h != 0) send_image_body(w * h, four, rle, 1'b1);
            else repeat ($urandom_range(0, 4)) send_byte(8'($urandom), 1'b0);
         end else begin
            // raw noise with the odd start of file
            repeat ($urandom_range(5, 20)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end
      end
   endtask

   initial begin
      clear_decoder();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_raw_pixels();
      test_run_length();
      test_header_rejects();
      test_empty_image();
      test_restart();
      test_truncated();
      test_output_stall();
      test_random_files();
      req_tvalid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d files; checked %0d results.",
               bytes_taken, files_sent, results_checked);
      $display("Raw and run-length images at 24 and 32 bits, header rejects, empty images,"
               , " restarts, truncated files and a long output stall.");
      if (errors == 0) begin
         $display("** tga_image_stream_decoder: PASSED **");
      end else begin
         $display("** tga_image_stream_decoder: FAILED **");
      end
      $finish;
   end

endmodule
